// ===== hw/rtl/plo_pkg.sv =====
package plo_pkg;

    localparam int MAX_INPUTS  = 16;
    localparam int MAX_OUTPUTS = 8;
    localparam int DATA_W      = 16;
    localparam int FRAC        = 12;
    localparam int SIG_DEPTH   = 256;
    localparam int COL_W       = 4;
    localparam int ROW_W       = 3;
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int CNT_W       = 5;
    localparam int NO_W        = 4;
    localparam int PROD_W      = 50;
    localparam int ACC_W       = 40;
    localparam int CFG_IDX_W   = 3;

    localparam logic [2:0] CFG_INPUTS  = 3'd0;
    localparam logic [2:0] CFG_OUTPUTS = 3'd1;
    localparam logic [2:0] CFG_RATE    = 3'd2;
    localparam logic [2:0] CFG_GAIN    = 3'd3;
    localparam logic [2:0] CFG_SIG_EN  = 3'd4;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_PUSH   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         weight_row;
        logic [3:0]         weight_col;
        logic signed [15:0] weight_value;
        logic signed [15:0] sample_value;
        logic               sample_last;
        logic signed [15:0] reward;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         output_index;
        logic signed [15:0] output_value;
        logic               output_last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_F_RD, ST_F_MUL, ST_F_ACC, ST_F_RND, ST_F_SIG1, ST_F_SIG2, ST_F_EMIT,
        ST_U_RD, ST_U_M1, ST_U_M2, ST_U_M3, ST_U_M4, ST_U_WR
    } state_t;

    typedef enum logic [2:0] {
        MUL_FWD, MUL_SIG, MUL_YW, MUL_PR, MUL_YD, MUL_RATE
    } mul_sel_t;

    typedef struct packed {
        logic             wr_weight;
        logic             push;
        logic             latch_rw;
        logic             acc_clr;
        logic             mem_rd;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic             acc_add;
        logic             rnd;
        logic             sig_look;
        logic             emit;
        logic             out_last;
        logic             upd_wr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] ni;
        logic [NO_W-1:0]  no;
        logic             sig_en;
        logic             out_free;
    } status_t;

    typedef logic [SIG_DEPTH-1:0][15:0] sig_tab_t;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic longint unsigned isqrt(input longint unsigned n_in);
        longint unsigned n, r, b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic sig_tab_t build_tab();
        sig_tab_t        tab;
        longint unsigned c [0:16];
        longint          zq;
        longint unsigned a, t, n, f, e, num, den, quo, rem;
        c[0] = 64'd1 << 29;
        for (int k = 1; k <= 16; k++) c[k] = isqrt(c[k-1] << 30);
        for (int i = 0; i < SIG_DEPTH; i++) begin
            zq = longint'(((64'(2 * i + 1)) << 19) >> $clog2(SIG_DEPTH)) - (64'sd1 <<< 19);
            a = (zq < 0) ? longint'(-zq) : longint'(zq);
            t = (a * 64'd1549082005 + (64'd1 << 29)) >> 30;
            n = t >> 16;
            f = t & 64'hffff;
            e = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (((f >> (16 - k)) & 64'd1) != 0) e = (e * c[k] + (64'd1 << 29)) >> 30;
            end
            e = (n < 31) ? (e >> n) : 64'd0;
            den = (64'd1 << 30) + e;
            num = (64'd1 << 42) + (den >> 1);
            quo = 0;
            rem = 0;
            for (int b = 63; b >= 0; b--) begin
                rem = (rem << 1) | ((num >> b) & 64'd1);
                if (rem >= den) begin
                    rem = rem - den;
                    quo = quo | (64'd1 << b);
                end
            end
            if (zq < 0) quo = (64'd1 << FRAC) - quo;
            tab[i] = quo[15:0];
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_tab();

endpackage

// ===== hw/rtl/plo_ctrl.sv =====
module plo_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  plo_pkg::in_item_t s_data,
    input  plo_pkg::status_t  stat,
    output plo_pkg::cmd_t     cmd
);

    plo_pkg::state_t state_reg, state_next;
    logic [plo_pkg::COL_W-1:0] i_reg, i_next;
    logic [plo_pkg::ROW_W-1:0] j_reg, j_next;
    logic last_i, last_j;

    assign last_i = ({1'b0, i_reg} == stat.ni - 5'd1);
    assign last_j = ({1'b0, j_reg} == stat.no - 4'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plo_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = plo_pkg::MUL_FWD;
        cmd.row      = j_reg;
        cmd.col      = i_reg;
        cmd.out_last = last_j;
        unique case (state_reg)
            plo_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                i_next  = '0;
                j_next  = '0;
                if (s_valid) begin
                    unique case (s_data.op)
                        plo_pkg::OP_WRITE: cmd.wr_weight = 1'b1;
                        plo_pkg::OP_PUSH: begin
                            cmd.push = 1'b1;
                            if (s_data.sample_last) begin
                                cmd.acc_clr = 1'b1;
                                state_next  = plo_pkg::ST_F_RD;
                            end
                        end
                        plo_pkg::OP_UPDATE: begin
                            cmd.latch_rw = 1'b1;
                            state_next   = plo_pkg::ST_U_RD;
                        end
                        plo_pkg::OP_IGNORE: ;
                        default: ;
                    endcase
                end
            end
            plo_pkg::ST_F_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = plo_pkg::ST_F_MUL;
            end
            plo_pkg::ST_F_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = plo_pkg::MUL_FWD;
                state_next  = plo_pkg::ST_F_ACC;
            end
            plo_pkg::ST_F_ACC: begin
                cmd.acc_add = 1'b1;
                if (last_i) begin
                    state_next = plo_pkg::ST_F_RND;
                end else begin
                    i_next     = i_reg + 4'd1;
                    state_next = plo_pkg::ST_F_RD;
                end
            end
            plo_pkg::ST_F_RND: begin
                cmd.rnd    = 1'b1;
                state_next = stat.sig_en ? plo_pkg::ST_F_SIG1 : plo_pkg::ST_F_EMIT;
            end
            plo_pkg::ST_F_SIG1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = plo_pkg::MUL_SIG;
                state_next  = plo_pkg::ST_F_SIG2;
            end
            plo_pkg::ST_F_SIG2: begin
                cmd.sig_look = 1'b1;
                state_next   = plo_pkg::ST_F_EMIT;
            end
            plo_pkg::ST_F_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.acc_clr = 1'b1;
                    i_next      = '0;
                    if (last_j) begin
                        state_next = plo_pkg::ST_IDLE;
                    end else begin
                        j_next     = j_reg + 3'd1;
                        state_next = plo_pkg::ST_F_RD;
                    end
                end
            end
            plo_pkg::ST_U_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = plo_pkg::ST_U_M1;
            end
            plo_pkg::ST_U_M1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = plo_pkg::MUL_YW;
                state_next  = plo_pkg::ST_U_M2;
            end
            plo_pkg::ST_U_M2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = plo_pkg::MUL_PR;
                state_next  = plo_pkg::ST_U_M3;
            end
            plo_pkg::ST_U_M3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = plo_pkg::MUL_YD;
                state_next  = plo_pkg::ST_U_M4;
            end
            plo_pkg::ST_U_M4: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = plo_pkg::MUL_RATE;
                state_next  = plo_pkg::ST_U_WR;
            end
            plo_pkg::ST_U_WR: begin
                cmd.upd_wr = 1'b1;
                if (last_i) begin
                    i_next = '0;
                    if (last_j) begin
                        state_next = plo_pkg::ST_IDLE;
                    end else begin
                        j_next     = j_reg + 3'd1;
                        state_next = plo_pkg::ST_U_RD;
                    end
                end else begin
                    i_next     = i_reg + 4'd1;
                    state_next = plo_pkg::ST_U_RD;
                end
            end
            default: state_next = plo_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/plo_dp.sv =====
module plo_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [plo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_wdata,
    input  plo_pkg::in_item_t                   s_data,
    input  plo_pkg::cmd_t                       cmd,
    output plo_pkg::status_t                    stat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output plo_pkg::out_item_t                  m_data
);

    localparam logic signed [63:0] HALF28 = 64'sd1 <<< 27;

    logic [4:0]  inputs_reg;
    logic [3:0]  outputs_reg;
    logic [15:0] rate_reg;
    logic [15:0] gain_reg;
    logic        sig_en_reg;

    logic signed [15:0] wmem [plo_pkg::MAX_OUTPUTS*plo_pkg::MAX_INPUTS];
    logic signed [15:0] rdata_reg;
    logic signed [15:0] xvec_reg [plo_pkg::MAX_INPUTS];
    logic signed [15:0] yvec_reg [plo_pkg::MAX_OUTPUTS];
    logic [plo_pkg::CNT_W-1:0] count_reg;
    logic signed [15:0] rw_reg;
    logic signed [plo_pkg::PROD_W-1:0] prod_reg;
    logic signed [plo_pkg::ACC_W-1:0]  acc_reg;
    logic signed [15:0] y_reg;
    logic               m_valid_reg;
    plo_pkg::out_item_t m_data_reg;

    logic [plo_pkg::ADDR_W-1:0] addr;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [15:0] x_cur, y_cur, p_val, q_val, d_val, w_new;
    logic signed [63:0] prod_ext, delta, sig_q;
    logic [7:0] sig_idx;

    assign addr     = {cmd.row, cmd.col};
    assign x_cur    = xvec_reg[cmd.col];
    assign y_cur    = yvec_reg[cmd.row];
    assign prod_ext = 64'(prod_reg);
    assign p_val    = plo_pkg::sat16(plo_pkg::rnd_shift(prod_ext, plo_pkg::FRAC));
    assign q_val    = plo_pkg::sat16(plo_pkg::rnd_shift(prod_ext, plo_pkg::FRAC));
    assign d_val    = plo_pkg::sat16(64'(x_cur) - 64'(q_val));
    assign delta    = plo_pkg::rnd_shift(prod_ext, 2 * plo_pkg::FRAC + 4);
    assign w_new    = plo_pkg::sat16(64'(rdata_reg) + delta);
    assign sig_q    = (prod_ext <<< 1) + HALF28;

    always_comb begin
        if (sig_q < 0) begin
            sig_idx = '0;
        end else if (sig_q > (HALF28 <<< 1) - 64'sd1) begin
            sig_idx = 8'hff;
        end else begin
            sig_idx = sig_q[27:20];
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            plo_pkg::MUL_FWD: begin
                mul_a = 33'(rdata_reg);
                mul_b = 17'(x_cur);
            end
            plo_pkg::MUL_SIG: begin
                mul_a = 33'(y_reg);
                mul_b = {1'b0, gain_reg};
            end
            plo_pkg::MUL_YW: begin
                mul_a = 33'(y_cur);
                mul_b = 17'(rdata_reg);
            end
            plo_pkg::MUL_PR: begin
                mul_a = 33'(p_val);
                mul_b = 17'(rw_reg);
            end
            plo_pkg::MUL_YD: begin
                mul_a = 33'(y_cur);
                mul_b = 17'(d_val);
            end
            plo_pkg::MUL_RATE: begin
                mul_a = 33'(signed'(prod_reg[31:0]));
                mul_b = {1'b0, rate_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        stat.ni       = (inputs_reg == 5'd0) ? 5'd1 :
                        (inputs_reg > 5'd16) ? 5'd16 : inputs_reg;
        stat.no       = (outputs_reg == 4'd0) ? 4'd1 :
                        (outputs_reg > 4'd8) ? 4'd8 : outputs_reg;
        stat.sig_en   = sig_en_reg;
        stat.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inputs_reg  <= 5'd16;
            outputs_reg <= 4'd8;
            rate_reg    <= '0;
            gain_reg    <= 16'd4096;
            sig_en_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                plo_pkg::CFG_INPUTS:  inputs_reg  <= cfg_wdata[4:0];
                plo_pkg::CFG_OUTPUTS: outputs_reg <= cfg_wdata[3:0];
                plo_pkg::CFG_RATE:    rate_reg    <= cfg_wdata;
                plo_pkg::CFG_GAIN:    gain_reg    <= cfg_wdata;
                plo_pkg::CFG_SIG_EN:  sig_en_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_weight) begin
            wmem[{s_data.weight_row, s_data.weight_col}] <= s_data.weight_value;
        end else if (cmd.upd_wr) begin
            wmem[addr] <= w_new;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= wmem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int k = 0; k < plo_pkg::MAX_INPUTS; k++) xvec_reg[k] <= '0;
            for (int k = 0; k < plo_pkg::MAX_OUTPUTS; k++) yvec_reg[k] <= '0;
        end else begin
            if (cmd.push) begin
                if (count_reg < stat.ni) begin
                    xvec_reg[count_reg[3:0]] <= s_data.sample_value;
                end
                if (s_data.sample_last) begin
                    count_reg <= '0;
                end else if (count_reg < 5'd16) begin
                    count_reg <= count_reg + 5'd1;
                end
            end
            if (cmd.emit) begin
                yvec_reg[cmd.row] <= y_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_rw) rw_reg <= s_data.reward;
        if (cmd.mul_en) prod_reg <= plo_pkg::PROD_W'(mul_a) * plo_pkg::PROD_W'(mul_b);
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + plo_pkg::ACC_W'(signed'(prod_reg[31:0]));
        end
        if (cmd.rnd) begin
            y_reg <= plo_pkg::sat16(plo_pkg::rnd_shift(64'(acc_reg), plo_pkg::FRAC));
        end else if (cmd.sig_look) begin
            y_reg <= plo_pkg::SIG_TAB[sig_idx];
        end
        if (cmd.emit) begin
            m_data_reg.output_index <= cmd.row;
            m_data_reg.output_value <= y_reg;
            m_data_reg.output_last  <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/perceptron_layer_oja_learning.sv =====
// Single-layer perceptron, up to 16 inputs by 8 outputs, Q4.12 weights held in an internal
// 128-entry store, with a reward-weighted Oja learning update. Op 0 writes one weight and
// op 3 is ignored. Op 1 pushes a sample; the sample marked last runs the forward pass, which
// for each output reads, multiplies and accumulates every input through the single shared
// multiplier, rounds, applies the gain and sigmoid table when enabled, waits until the output
// register is free (empty or taken on m_ready), and emits one item per output. Op 2 updates
// every weight in use, one multiplier pass after another. A new item is taken only once the
// current operation has finished.
module perceptron_layer_oja_learning (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [plo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  plo_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output plo_pkg::out_item_t            m_data
);

    plo_pkg::cmd_t    cmd;
    plo_pkg::status_t stat;

    plo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .stat    (stat),
        .cmd     (cmd)
    );

    plo_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
